// ----- rtl/ndef_pkg.sv -----
// shared types and constants of the ndef record header parser
// phase encoding, byte kind and status codes, flag bit positions
// no dependencies
`default_nettype none

package ndef_pkg;

	// flags byte bit positions
	localparam int unsigned FlagMb = 7;
	localparam int unsigned FlagMe = 6;
	localparam int unsigned FlagCf = 5;
	localparam int unsigned FlagSr = 4;
	localparam int unsigned FlagIl = 3;

	localparam logic [2:0] KIND_HEADER  = 3'd0;
	localparam logic [2:0] KIND_TYPE    = 3'd1;
	localparam logic [2:0] KIND_ID      = 3'd2;
	localparam logic [2:0] KIND_BODY    = 3'd3;
	localparam logic [2:0] KIND_IGNORED = 3'd4;

	localparam logic [1:0] ST_PENDING = 2'd0;
	localparam logic [1:0] ST_SUCCESS = 2'd1;
	localparam logic [1:0] ST_CHUNKED = 2'd2;
	localparam logic [1:0] ST_SHORT   = 2'd3;

	// field to enter after a header byte or a finished field
	localparam logic [1:0] FIELD_TYPE = 2'd0;
	localparam logic [1:0] FIELD_ID   = 2'd1;
	localparam logic [1:0] FIELD_BODY = 2'd2;

	typedef enum logic [9:0] {
		PH_FLAGS   = 10'b00_0000_0001,
		PH_TYPELEN = 10'b00_0000_0010,
		PH_PLEN    = 10'b00_0000_0100,
		PH_IDLEN   = 10'b00_0000_1000,
		PH_TYPE    = 10'b00_0001_0000,
		PH_ID      = 10'b00_0010_0000,
		PH_BODY    = 10'b00_0100_0000,
		PH_TRAIL   = 10'b00_1000_0000,
		PH_CHUNK1  = 10'b01_0000_0000,
		PH_CHUNK2  = 10'b10_0000_0000
	} phase_t;

endpackage

`default_nettype wire

// ----- rtl/ndef_record_parser_top.sv -----
// ndef record header parser, top level
// one byte per item in, one tagged byte with header fields per item out
// depends on ndef_pkg
`default_nettype none

// usage
//  input channel: item_valid / item_ready carry data_byte and last_byte,
//    one raw byte of the record buffer per item, last_byte on its final byte
//  output channel: result_valid / result_ready carry one result per input
//    item: the byte passed through, its kind (header, type, id, payload,
//    ignored), the header fields parsed so far and the verdict status
//  latency: the result of an item is valid the cycle after it is accepted
//  throughput: one item per cycle while result_ready is high; the parser state
//    and the result register are updated in the same cycle the item is taken
//  stall: the result register holds its item while result_ready is low;
//    item_ready then drops until the result is taken, so nothing is lost
//  verdict: status is pending on every byte but the last; on the last byte
//    it gives success, chunked unsupported or too short
//  reset: arst_n clears the parser to expect a flags byte and empties the
//    result register; after every last byte the parser returns to the same
//    state and takes the next byte as a new record's flags byte
module ndef_record_parser_top (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        item_valid,
	output logic             item_ready,
	input  wire logic [7:0]  data_byte,
	input  wire logic        last_byte,
	output logic             result_valid,
	input  wire logic        result_ready,
	output logic [2:0]       byte_kind,
	output logic [7:0]       byte_value,
	output logic             header_done,
	output logic [2:0]       name_format,
	output logic             message_begin,
	output logic             message_end,
	output logic             short_record,
	output logic [7:0]       kind_length,
	output logic [7:0]       ident_length,
	output logic [31:0]      body_length,
	output logic [1:0]       status
);

	// parser state
	ndef_pkg::phase_t phase_q;
	logic [7:0]       flags_q;
	logic [7:0]       kind_len_q;
	logic [7:0]       ident_len_q;
	logic [31:0]      body_len_q;
	logic [31:0]      remaining_q;
	logic [1:0]       len_idx_q;
	logic             complete_q;

	// next state
	ndef_pkg::phase_t phase_d;
	logic [7:0]       flags_d;
	logic [7:0]       kind_len_d;
	logic [7:0]       ident_len_d;
	logic [31:0]      body_len_d;
	logic [31:0]      remaining_d;
	logic [1:0]       len_idx_d;
	logic             complete_d;

	// per-item result
	logic [2:0] kind_c;
	logic [1:0] status_c;
	logic       hdr_c;
	logic       chunk_short;
	logic       enter_en;
	logic [1:0] enter_which;
	logic       accept;

	// one output register: a new item may enter while the old result leaves
	assign item_ready = !result_valid || result_ready;
	assign accept     = item_valid && item_ready;

	always_comb begin
		phase_d     = phase_q;
		flags_d     = flags_q;
		kind_len_d  = kind_len_q;
		ident_len_d = ident_len_q;
		body_len_d  = body_len_q;
		remaining_d = remaining_q;
		len_idx_d   = len_idx_q;
		complete_d  = complete_q;
		kind_c      = ndef_pkg::KIND_IGNORED;
		chunk_short = 1'b0;
		enter_en    = 1'b0;
		enter_which = ndef_pkg::FIELD_TYPE;

		case (phase_q)
			ndef_pkg::PH_FLAGS: begin
				kind_c      = ndef_pkg::KIND_HEADER;
				flags_d     = data_byte;
				phase_d     = data_byte[ndef_pkg::FlagCf] ? ndef_pkg::PH_CHUNK1
				                                          : ndef_pkg::PH_TYPELEN;
				chunk_short = 1'b1;
			end
			ndef_pkg::PH_TYPELEN: begin
				kind_c     = ndef_pkg::KIND_HEADER;
				kind_len_d = data_byte;
				body_len_d = '0;
				len_idx_d  = '0;
				phase_d    = ndef_pkg::PH_PLEN;
			end
			ndef_pkg::PH_PLEN: begin
				kind_c = ndef_pkg::KIND_HEADER;
				// short form is one byte, long form shifts in big-endian
				if (flags_q[ndef_pkg::FlagSr]) begin
					body_len_d = {24'd0, data_byte};
				end else begin
					body_len_d = {body_len_q[23:0], data_byte};
				end
				if (flags_q[ndef_pkg::FlagSr] || len_idx_q == 2'd3) begin
					len_idx_d = '0;
					if (flags_q[ndef_pkg::FlagIl]) begin
						phase_d = ndef_pkg::PH_IDLEN;
					end else begin
						ident_len_d = '0;
						enter_en    = 1'b1;
						enter_which = ndef_pkg::FIELD_TYPE;
					end
				end else begin
					len_idx_d = len_idx_q + 2'd1;
				end
			end
			ndef_pkg::PH_IDLEN: begin
				kind_c      = ndef_pkg::KIND_HEADER;
				ident_len_d = data_byte;
				enter_en    = 1'b1;
				enter_which = ndef_pkg::FIELD_TYPE;
			end
			ndef_pkg::PH_TYPE: begin
				kind_c      = ndef_pkg::KIND_TYPE;
				remaining_d = remaining_q - 32'd1;
				if (remaining_q == 32'd1) begin
					enter_en    = 1'b1;
					enter_which = ndef_pkg::FIELD_ID;
				end
			end
			ndef_pkg::PH_ID: begin
				kind_c      = ndef_pkg::KIND_ID;
				remaining_d = remaining_q - 32'd1;
				if (remaining_q == 32'd1) begin
					enter_en    = 1'b1;
					enter_which = ndef_pkg::FIELD_BODY;
				end
			end
			ndef_pkg::PH_BODY: begin
				kind_c      = ndef_pkg::KIND_BODY;
				remaining_d = remaining_q - 32'd1;
				if (remaining_q == 32'd1) begin
					phase_d    = ndef_pkg::PH_TRAIL;
					complete_d = 1'b1;
				end
			end
			ndef_pkg::PH_CHUNK1: begin
				phase_d     = ndef_pkg::PH_CHUNK2;
				chunk_short = 1'b1;
			end
			ndef_pkg::PH_CHUNK2: begin
				phase_d = ndef_pkg::PH_CHUNK2;
			end
			default: begin
				// trailing bytes after a complete record
				phase_d = phase_q;
			end
		endcase

		// skip empty fields, using the lengths as updated by this byte
		if (enter_en) begin
			if (enter_which == ndef_pkg::FIELD_TYPE && kind_len_d != 8'd0) begin
				phase_d     = ndef_pkg::PH_TYPE;
				remaining_d = {24'd0, kind_len_d};
			end else if (enter_which != ndef_pkg::FIELD_BODY && ident_len_d != 8'd0) begin
				phase_d     = ndef_pkg::PH_ID;
				remaining_d = {24'd0, ident_len_d};
			end else if (body_len_d != 32'd0) begin
				phase_d     = ndef_pkg::PH_BODY;
				remaining_d = body_len_d;
			end else begin
				phase_d     = ndef_pkg::PH_TRAIL;
				remaining_d = '0;
				complete_d  = 1'b1;
			end
		end

		hdr_c = (phase_d == ndef_pkg::PH_TYPE) || (phase_d == ndef_pkg::PH_ID) ||
		        (phase_d == ndef_pkg::PH_BODY) || (phase_d == ndef_pkg::PH_TRAIL);

		status_c = ndef_pkg::ST_PENDING;
		if (last_byte) begin
			if (phase_d == ndef_pkg::PH_CHUNK1 || phase_d == ndef_pkg::PH_CHUNK2) begin
				status_c = chunk_short ? ndef_pkg::ST_SHORT : ndef_pkg::ST_CHUNKED;
			end else begin
				status_c = complete_d ? ndef_pkg::ST_SUCCESS : ndef_pkg::ST_SHORT;
			end
		end
	end

	// parser state: back to the flags byte after every last byte
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= ndef_pkg::PH_FLAGS;
			flags_q     <= '0;
			kind_len_q  <= '0;
			ident_len_q <= '0;
			body_len_q  <= '0;
			remaining_q <= '0;
			len_idx_q   <= '0;
			complete_q  <= 1'b0;
		end else if (accept) begin
			if (last_byte) begin
				phase_q     <= ndef_pkg::PH_FLAGS;
				flags_q     <= '0;
				kind_len_q  <= '0;
				ident_len_q <= '0;
				body_len_q  <= '0;
				remaining_q <= '0;
				len_idx_q   <= '0;
				complete_q  <= 1'b0;
			end else begin
				phase_q     <= phase_d;
				flags_q     <= flags_d;
				kind_len_q  <= kind_len_d;
				ident_len_q <= ident_len_d;
				body_len_q  <= body_len_d;
				remaining_q <= remaining_d;
				len_idx_q   <= len_idx_d;
				complete_q  <= complete_d;
			end
		end
	end

	// result register valid flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid <= 1'b0;
		end else if (item_ready) begin
			result_valid <= item_valid;
		end
	end

	// result payload, loaded with the item
	always_ff @(posedge clk) begin
		if (accept) begin
			byte_kind     <= kind_c;
			byte_value    <= data_byte;
			header_done   <= hdr_c;
			name_format   <= flags_d[2:0];
			message_begin <= flags_d[ndef_pkg::FlagMb];
			message_end   <= flags_d[ndef_pkg::FlagMe];
			short_record  <= flags_d[ndef_pkg::FlagSr];
			kind_length   <= kind_len_d;
			ident_length  <= ident_len_d;
			body_length   <= body_len_d;
			status        <= status_c;
		end
	end

	// a complete record only sits in the trailing phase
	a_complete_trail: assert property (@(posedge clk) disable iff (!arst_n)
		complete_q |-> phase_q == ndef_pkg::PH_TRAIL)
		else $error("record complete outside trailing phase");

	// a field phase always has bytes left to count
	a_remaining: assert property (@(posedge clk) disable iff (!arst_n)
		(phase_q == ndef_pkg::PH_TYPE || phase_q == ndef_pkg::PH_ID ||
		 phase_q == ndef_pkg::PH_BODY) |-> remaining_q != 32'd0)
		else $error("field phase with zero bytes remaining");

	// the last byte returns the parser to the flags byte
	a_last_restart: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && last_byte) |=> phase_q == ndef_pkg::PH_FLAGS && !complete_q)
		else $error("parser did not restart after last byte");

endmodule

`default_nettype wire

// ----- sim/tb_top.sv -----
`timescale 1ns / 1ps
// self-checking testbench for the ndef record header parser
// a directed table and random records are driven through a byte-level predictor
// depends on ndef_pkg and ndef_record_parser_top

module tb_top;

	localparam int RandItems = 2000;
	localparam int HoldOff = 300;      // the long receiver stall, in cycles
	localparam int QuietLimit = 5000;  // cycles with no item moving before giving up
	localparam int TailCycles = 4;     // a result shows up the cycle after its item

	localparam logic NoPin = 1'b0;
	localparam logic Pin = 1'b1;

	// one row of the directed table; kind and status are compared as typed only on
	// pinned rows, everything else comes from the predictor
	typedef struct packed {
		logic [7:0] data;
		logic       last;
		logic       pinned;
		logic [2:0] kind;
		logic [1:0] status;
	} stim_row_t;

	// everything the parser reports for one byte
	typedef struct packed {
		logic [2:0]  kind;
		logic [7:0]  value;
		logic        hdr_done;
		logic [2:0]  tnf;
		logic        mb;
		logic        me;
		logic        sr;
		logic [7:0]  klen;
		logic [7:0]  ilen;
		logic [31:0] blen;
		logic [1:0]  status;
	} tagged_byte_t;

	localparam int DirRows = 24;
	stim_row_t directed_rows [DirRows] = '{
		// single flags byte straight after reset
		'{8'h00, 1'b1, Pin,   ndef_pkg::KIND_HEADER,  ndef_pkg::ST_SHORT},
		// short form with every field empty, complete on its last header byte
		'{8'h10, 1'b0, NoPin, ndef_pkg::KIND_HEADER,  ndef_pkg::ST_PENDING},
		'{8'h00, 1'b0, NoPin, ndef_pkg::KIND_HEADER,  ndef_pkg::ST_PENDING},
		'{8'h00, 1'b1, Pin,   ndef_pkg::KIND_HEADER,  ndef_pkg::ST_SUCCESS},
		// chunked, three bytes
		'{8'h20, 1'b0, NoPin, ndef_pkg::KIND_HEADER,  ndef_pkg::ST_PENDING},
		'{8'h00, 1'b0, NoPin, ndef_pkg::KIND_HEADER,  ndef_pkg::ST_PENDING},
		'{8'h00, 1'b1, Pin,   ndef_pkg::KIND_IGNORED, ndef_pkg::ST_CHUNKED},
		// chunked but only two bytes
		'{8'h3F, 1'b0, NoPin, ndef_pkg::KIND_HEADER,  ndef_pkg::ST_PENDING},
		'{8'hFF, 1'b1, Pin,   ndef_pkg::KIND_IGNORED, ndef_pkg::ST_SHORT},
		// short form, all lengths at max, cut off after the id length
		'{8'hDF, 1'b0, NoPin, ndef_pkg::KIND_HEADER,  ndef_pkg::ST_PENDING},
		'{8'hFF, 1'b0, NoPin, ndef_pkg::KIND_HEADER,  ndef_pkg::ST_PENDING},
		'{8'hFF, 1'b0, NoPin, ndef_pkg::KIND_HEADER,  ndef_pkg::ST_PENDING},
		'{8'hFF, 1'b1, Pin,   ndef_pkg::KIND_HEADER,  ndef_pkg::ST_SHORT},
		// long form with type, id, payload and one trailing byte
		'{8'hCF, 1'b0, NoPin, ndef_pkg::KIND_HEADER,  ndef_pkg::ST_PENDING},
		'{8'h01, 1'b0, NoPin, ndef_pkg::KIND_HEADER,  ndef_pkg::ST_PENDING},
		'{8'h00, 1'b0, NoPin, ndef_pkg::KIND_HEADER,  ndef_pkg::ST_PENDING},
		'{8'h00, 1'b0, NoPin, ndef_pkg::KIND_HEADER,  ndef_pkg::ST_PENDING},
		'{8'h00, 1'b0, NoPin, ndef_pkg::KIND_HEADER,  ndef_pkg::ST_PENDING},
		'{8'h01, 1'b0, NoPin, ndef_pkg::KIND_HEADER,  ndef_pkg::ST_PENDING},
		'{8'h01, 1'b0, NoPin, ndef_pkg::KIND_HEADER,  ndef_pkg::ST_PENDING},
		'{8'h54, 1'b0, NoPin, ndef_pkg::KIND_HEADER,  ndef_pkg::ST_PENDING},
		'{8'hFF, 1'b0, NoPin, ndef_pkg::KIND_HEADER,  ndef_pkg::ST_PENDING},
		'{8'h80, 1'b0, NoPin, ndef_pkg::KIND_HEADER,  ndef_pkg::ST_PENDING},
		'{8'hAA, 1'b1, Pin,   ndef_pkg::KIND_IGNORED, ndef_pkg::ST_SUCCESS}
	};

	// clock, reset and block ports; every input known from time zero
	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        item_valid = 1'b0;
	logic        item_ready;
	logic [7:0]  data_byte = 8'h00;
	logic        last_byte = 1'b0;
	logic        result_valid;
	logic        result_ready = 1'b0;
	logic [2:0]  byte_kind;
	logic [7:0]  byte_value;
	logic        header_done;
	logic [2:0]  name_format;
	logic        message_begin;
	logic        message_end;
	logic        short_record;
	logic [7:0]  kind_length;
	logic [7:0]  ident_length;
	logic [31:0] body_length;
	logic [1:0]  status;

	// predictor state, a shadow of the parser
	ndef_pkg::phase_t ps_phase;
	logic [7:0]  ps_flags;
	logic [7:0]  ps_klen;
	logic [7:0]  ps_ilen;
	logic [31:0] ps_blen;
	logic [31:0] ps_remain;
	logic [1:0]  ps_lidx;
	logic        ps_complete;

	tagged_byte_t tagged_bytes_due[$];   // predicted results, oldest first
	logic [7:0]   rec_bytes[$];          // the record being sent
	int           mismatches = 0;
	int           items_sent = 0;
	int           quiet_cycles = 0;
	bit           burst_mode = 1'b0;     // no sender gaps while set
	bit           stall_results = 1'b0;  // asks the receiver for its long hold-off
	bit           stall_served = 1'b0;

	ndef_record_parser_top dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (item_valid),
		.item_ready   (item_ready),
		.data_byte    (data_byte),
		.last_byte    (last_byte),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.byte_kind    (byte_kind),
		.byte_value   (byte_value),
		.header_done  (header_done),
		.name_format  (name_format),
		.message_begin(message_begin),
		.message_end  (message_end),
		.short_record (short_record),
		.kind_length  (kind_length),
		.ident_length (ident_length),
		.body_length  (body_length),
		.status       (status)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// back to waiting for a flags byte
	function automatic void clear_parser();
		ps_phase = ndef_pkg::PH_FLAGS;
		ps_flags = '0;
		ps_klen = '0;
		ps_ilen = '0;
		ps_blen = '0;
		ps_remain = '0;
		ps_lidx = '0;
		ps_complete = 1'b0;
	endfunction

	// move on to the first non-empty field at or after the one named
	function automatic void enter_field(input logic [1:0] which);
		if (which == ndef_pkg::FIELD_TYPE && ps_klen != 8'd0) begin
			ps_phase = ndef_pkg::PH_TYPE;
			ps_remain = {24'd0, ps_klen};
		end else if (which != ndef_pkg::FIELD_BODY && ps_ilen != 8'd0) begin
			ps_phase = ndef_pkg::PH_ID;
			ps_remain = {24'd0, ps_ilen};
		end else if (ps_blen != 32'd0) begin
			ps_phase = ndef_pkg::PH_BODY;
			ps_remain = ps_blen;
		end else begin
			ps_phase = ndef_pkg::PH_TRAIL;
			ps_remain = '0;
			ps_complete = 1'b1;
		end
	endfunction

	// tags one byte, updates the shadow state and gives what the parser should report
	function automatic tagged_byte_t parse_byte(input logic [7:0] b, input logic last);
		tagged_byte_t r;
		logic [2:0] kind;
		logic early;   // buffer still too short to call it chunked
		kind = ndef_pkg::KIND_IGNORED;
		early = 1'b0;
		case (ps_phase)
			ndef_pkg::PH_FLAGS: begin
				kind = ndef_pkg::KIND_HEADER;
				ps_flags = b;
				ps_phase = b[ndef_pkg::FlagCf] ? ndef_pkg::PH_CHUNK1 : ndef_pkg::PH_TYPELEN;
				early = 1'b1;
			end
			ndef_pkg::PH_TYPELEN: begin
				kind = ndef_pkg::KIND_HEADER;
				ps_klen = b;
				ps_blen = '0;
				ps_lidx = '0;
				ps_phase = ndef_pkg::PH_PLEN;
			end
			ndef_pkg::PH_PLEN: begin
				kind = ndef_pkg::KIND_HEADER;
				if (ps_flags[ndef_pkg::FlagSr])
					ps_blen = {24'd0, b};
				else
					ps_blen = {ps_blen[23:0], b};
				if (ps_flags[ndef_pkg::FlagSr] || ps_lidx == 2'd3) begin
					ps_lidx = '0;
					if (ps_flags[ndef_pkg::FlagIl]) begin
						ps_phase = ndef_pkg::PH_IDLEN;
					end else begin
						ps_ilen = '0;
						enter_field(ndef_pkg::FIELD_TYPE);
					end
				end else begin
					ps_lidx = ps_lidx + 2'd1;
				end
			end
			ndef_pkg::PH_IDLEN: begin
				kind = ndef_pkg::KIND_HEADER;
				ps_ilen = b;
				enter_field(ndef_pkg::FIELD_TYPE);
			end
			ndef_pkg::PH_TYPE, ndef_pkg::PH_ID, ndef_pkg::PH_BODY: begin
				kind = (ps_phase == ndef_pkg::PH_TYPE) ? ndef_pkg::KIND_TYPE :
					(ps_phase == ndef_pkg::PH_ID) ? ndef_pkg::KIND_ID : ndef_pkg::KIND_BODY;
				ps_remain = ps_remain - 32'd1;
				if (ps_remain == 32'd0) begin
					if (kind == ndef_pkg::KIND_TYPE) begin
						enter_field(ndef_pkg::FIELD_ID);
					end else if (kind == ndef_pkg::KIND_ID) begin
						enter_field(ndef_pkg::FIELD_BODY);
					end else begin
						ps_phase = ndef_pkg::PH_TRAIL;
						ps_complete = 1'b1;
					end
				end
			end
			ndef_pkg::PH_CHUNK1: begin
				ps_phase = ndef_pkg::PH_CHUNK2;
				early = 1'b1;
			end
			default: begin
			end
		endcase

		r.kind = kind;
		r.value = b;
		r.hdr_done = (ps_phase == ndef_pkg::PH_TYPE || ps_phase == ndef_pkg::PH_ID ||
			ps_phase == ndef_pkg::PH_BODY || ps_phase == ndef_pkg::PH_TRAIL);
		r.tnf = ps_flags[2:0];
		r.mb = ps_flags[ndef_pkg::FlagMb];
		r.me = ps_flags[ndef_pkg::FlagMe];
		r.sr = ps_flags[ndef_pkg::FlagSr];
		r.klen = ps_klen;
		r.ilen = ps_ilen;
		r.blen = ps_blen;
		r.status = ndef_pkg::ST_PENDING;
		if (last) begin
			if (ps_phase == ndef_pkg::PH_CHUNK1 || ps_phase == ndef_pkg::PH_CHUNK2)
				r.status = early ? ndef_pkg::ST_SHORT : ndef_pkg::ST_CHUNKED;
			else
				r.status = ps_complete ? ndef_pkg::ST_SUCCESS : ndef_pkg::ST_SHORT;
			clear_parser();
		end
		return r;
	endfunction

	function automatic void check_field(input string field, input logic [31:0] want,
			input logic [31:0] got);
		if (got !== want) begin
			$error("%s: expected %0h, got %0h", field, want, got);
			mismatches++;
		end
	endfunction

	// offers one item, waits for it to be taken, records what it should give,
	// then maybe leaves a gap before the next one
	task automatic send_item(input logic [7:0] d, input logic l, input logic pin,
			input logic [2:0] kind, input logic [1:0] st);
		tagged_byte_t due;
		int sel;
		int gap;
		item_valid <= 1'b1;
		data_byte <= d;
		last_byte <= l;
		do
			@(posedge clk);
		while (!item_ready);
		due = parse_byte(d, l);
		if (pin) begin
			due.kind = kind;
			due.status = st;
		end
		tagged_bytes_due.push_back(due);
		items_sent++;
		// mostly back to back or short gaps, now and then a long one
		sel = $urandom_range(0, 99);
		gap = 0;
		if (!burst_mode) begin
			if (sel >= 93)
				gap = $urandom_range(10, 40);
			else if (sel >= 55)
				gap = $urandom_range(1, 3);
		end
		if (gap > 0) begin
			item_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	// stimulus: reset, the directed table, then random records
	initial begin
		int sel;
		int cut;
		int n;
		logic [7:0] flags;
		logic [7:0] klen;
		logic [7:0] ilen;
		logic [31:0] blen;
		bit paused;
		paused = 1'b0;
		clear_parser();
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (directed_rows[i])
			send_item(directed_rows[i].data, directed_rows[i].last, directed_rows[i].pinned,
				directed_rows[i].kind, directed_rows[i].status);

		while (items_sent < DirRows + RandItems) begin
			// long receiver stall once the random part is under way
			if (items_sent >= 300)
				stall_results = 1'b1;
			// one pause with nothing in flight, on a record boundary
			if (items_sent >= 1000 && !paused) begin
				paused = 1'b1;
				item_valid <= 1'b0;
				while (tagged_bytes_due.size() != 0)
					@(posedge clk);
			end
			burst_mode = ($urandom_range(0, 3) == 0);
			rec_bytes.delete();
			sel = $urandom_range(0, 99);
			if (sel < 75) begin
				// well-formed record with random content, mostly small lengths
				flags = 8'($urandom_range(0, 255));
				flags[ndef_pkg::FlagCf] = 1'b0;
				klen = ($urandom_range(0, 99) == 0) ? 8'($urandom_range(0, 255))
					: 8'($urandom_range(0, 4));
				ilen = ($urandom_range(0, 99) == 0) ? 8'($urandom_range(0, 255))
					: 8'($urandom_range(0, 4));
				blen = ($urandom_range(0, 19) == 0) ? 32'($urandom)
					: 32'($urandom_range(0, 8));
				if (flags[ndef_pkg::FlagSr])
					blen = {24'd0, blen[7:0]};
				rec_bytes.push_back(flags);
				rec_bytes.push_back(klen);
				if (flags[ndef_pkg::FlagSr]) begin
					rec_bytes.push_back(blen[7:0]);
				end else begin
					rec_bytes.push_back(blen[31:24]);
					rec_bytes.push_back(blen[23:16]);
					rec_bytes.push_back(blen[15:8]);
					rec_bytes.push_back(blen[7:0]);
				end
				if (flags[ndef_pkg::FlagIl])
					rec_bytes.push_back(ilen);
				repeat (klen) rec_bytes.push_back(8'($urandom_range(0, 255)));
				if (flags[ndef_pkg::FlagIl])
					repeat (ilen) rec_bytes.push_back(8'($urandom_range(0, 255)));
				// a huge payload never completes, so only send a few of its bytes
				n = (blen > 32'd64) ? int'($urandom_range(0, 20)) : int'(blen);
				repeat (n) rec_bytes.push_back(8'($urandom_range(0, 255)));
				if ($urandom_range(0, 3) == 0)
					repeat ($urandom_range(1, 3)) rec_bytes.push_back(8'($urandom_range(0, 255)));
				// some records are cut short
				if ($urandom_range(0, 9) == 0) begin
					cut = $urandom_range(1, rec_bytes.size());
					rec_bytes = rec_bytes[0:cut-1];
				end
			end else if (sel < 85) begin
				// chunked record of one to five bytes
				flags = 8'($urandom_range(0, 255));
				flags[ndef_pkg::FlagCf] = 1'b1;
				rec_bytes.push_back(flags);
				repeat ($urandom_range(0, 4)) rec_bytes.push_back(8'($urandom_range(0, 255)));
			end else begin
				// plain noise
				repeat ($urandom_range(1, 6)) rec_bytes.push_back(8'($urandom_range(0, 255)));
			end
			foreach (rec_bytes[i])
				send_item(rec_bytes[i], i == rec_bytes.size() - 1, NoPin,
					ndef_pkg::KIND_HEADER, ndef_pkg::ST_PENDING);
		end
		item_valid <= 1'b0;

		// drain, let the last result settle, then report
		while (tagged_bytes_due.size() != 0)
			@(posedge clk);
		repeat (TailCycles) @(posedge clk);
		if (mismatches == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

	// receiver: random ready pattern, plus one long hold-off on request
	initial begin
		int sel;
		int span;
		wait (arst_n === 1'b1);
		forever begin
			if (stall_results && !stall_served) begin
				result_ready <= 1'b0;
				repeat (HoldOff) @(posedge clk);
				stall_served = 1'b1;
			end else begin
				sel = $urandom_range(0, 99);
				if (sel < 50) begin
					result_ready <= 1'b1;
					span = $urandom_range(1, 20);
				end else if (sel < 92) begin
					result_ready <= 1'b0;
					span = $urandom_range(1, 3);
				end else begin
					result_ready <= 1'b0;
					span = $urandom_range(10, 40);
				end
				repeat (span) @(posedge clk);
			end
		end
	end

	// compare every taken result against the oldest prediction
	always @(posedge clk) begin
		tagged_byte_t due;
		if (arst_n && result_valid && result_ready) begin
			if (tagged_bytes_due.size() == 0) begin
				$error("result with nothing expected, byte_value %0h", byte_value);
				mismatches++;
			end else begin
				due = tagged_bytes_due.pop_front();
				check_field("byte_kind", 32'(due.kind), 32'(byte_kind));
				check_field("byte_value", 32'(due.value), 32'(byte_value));
				check_field("header_done", 32'(due.hdr_done), 32'(header_done));
				check_field("name_format", 32'(due.tnf), 32'(name_format));
				check_field("message_begin", 32'(due.mb), 32'(message_begin));
				check_field("message_end", 32'(due.me), 32'(message_end));
				check_field("short_record", 32'(due.sr), 32'(short_record));
				check_field("kind_length", 32'(due.klen), 32'(kind_length));
				check_field("ident_length", 32'(due.ilen), 32'(ident_length));
				check_field("body_length", due.blen, body_length);
				check_field("status", 32'(due.status), 32'(status));
			end
		end
	end

	// watchdog: too long with nothing moving on either side
	always @(posedge clk) begin
		if (!arst_n || (item_valid && item_ready) || (result_valid && result_ready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= QuietLimit) begin
			$display("Verification failed");
			$finish;
		end
	end

endmodule
